// ===== sv/acfm_pkg.sv =====
// Shared types and constants for the ANSI cell stream formatter.
// Holds the job record passed from the front end through the queue to the
// back end. No dependencies.
package acfm_pkg;

    // Job queue depth and derived widths
    localparam int ACFM_QDEPTH = 2;
    localparam int ACFM_QPTR_W = (ACFM_QDEPTH > 1) ? $clog2(ACFM_QDEPTH) : 1;
    localparam int ACFM_QCNT_W = $clog2(ACFM_QDEPTH + 1);

    // Number of decimal slots: fg r/g/b in 0..2, bg r/g/b in 3..5.
    // Sixteen-colour codes use slot 0 (fg) and slot 3 (bg).
    localparam int ACFM_SLOTS = 6;

    // One classified cell, ready to serialize
    typedef struct packed {
        logic                                home;        // send ESC [H first
        logic                                true_color;  // 38;2 / 48;2 escape
        logic                                color_16;    // sixteen-colour escape
        logic                                with_bg;     // background part present
        logic                                row_end;     // reset + newline at end
        logic [ACFM_SLOTS-1:0][2:0][3:0]     digits;      // digit 0 printed first
        logic [ACFM_SLOTS-1:0][1:0]          dlen;        // 1..3 digits
        logic [3:0][7:0]                     utf;         // byte 0 sent first
        logic [2:0]                          ulen;        // 1..4 bytes
    } acfm_job_t;

endpackage

// ===== sv/acfm_front.sv =====
// Front end: configuration registers, input acceptance and classification.
// Converts colour values to decimal digits and the codepoint to UTF-8.
// Depends on acfm_pkg.
module acfm_front
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_wdata,
    // cell input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [87:0]        s_tdata,
    input  logic               s_tuser,
    input  logic               s_tlast,
    // job queue write side
    output logic               job_valid,
    input  logic               job_ready,
    output acfm_pkg::acfm_job_t job
);

    localparam logic [1:0] REG_COLOR_DEPTH = 2'd0;
    localparam logic [1:0] REG_TRANSP_BG   = 2'd1;
    localparam logic [1:0] REG_SCREEN_CTRL = 2'd2;

    localparam logic [1:0] DEPTH_16   = 2'd1;
    localparam logic [1:0] DEPTH_TRUE = 2'd2;

    logic [1:0] color_depth_reg;
    logic       transp_bg_reg;
    logic       screen_ctrl_reg;

    logic [7:0]  fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue;
    logic [7:0]  fg_code, bg_code, bg_code_10;
    logic [20:0] codepoint;
    logic [acfm_pkg::ACFM_SLOTS-1:0][7:0] slot_val;
    logic [13:0] dec_res [acfm_pkg::ACFM_SLOTS];
    logic        is_16;

    // Binary to decimal by shift-and-add-3; returns {len, digits first-printed low}
    function automatic logic [13:0] dec8(input logic [7:0] v);
        logic [11:0] bcd;
        logic [13:0] r;
        int          i;
        bcd = '0;
        for (i = 7; i >= 0; i--)
        begin
            if (bcd[3:0] >= 4'd5)
                bcd[3:0] = bcd[3:0] + 4'd3;
            if (bcd[7:4] >= 4'd5)
                bcd[7:4] = bcd[7:4] + 4'd3;
            if (bcd[11:8] >= 4'd5)
                bcd[11:8] = bcd[11:8] + 4'd3;
            bcd = {bcd[10:0], v[i]};
        end
        if (bcd[11:8] != 4'd0)
            r = {2'd3, bcd[3:0], bcd[7:4], bcd[11:8]};
        else if (bcd[7:4] != 4'd0)
            r = {2'd2, 4'd0, bcd[3:0], bcd[7:4]};
        else
            r = {2'd1, 8'd0, bcd[3:0]};
        return r;
    endfunction

    // Hold configuration; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_depth_reg <= DEPTH_TRUE;
            transp_bg_reg   <= 1'b0;
            screen_ctrl_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COLOR_DEPTH: color_depth_reg <= cfg_wdata;
                REG_TRANSP_BG:   transp_bg_reg   <= cfg_wdata[0];
                REG_SCREEN_CTRL: screen_ctrl_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Unpack the beat
    assign fg_red     = s_tdata[7:0];
    assign fg_green   = s_tdata[15:8];
    assign fg_blue    = s_tdata[23:16];
    assign bg_red     = s_tdata[31:24];
    assign bg_green   = s_tdata[39:32];
    assign bg_blue    = s_tdata[47:40];
    assign fg_code    = s_tdata[55:48];
    assign bg_code    = s_tdata[63:56];
    assign codepoint  = s_tdata[84:64];
    assign bg_code_10 = bg_code + 8'd10;

    assign is_16 = (color_depth_reg == DEPTH_16);

    // Select the values to print per slot
    always_comb
    begin
        slot_val[0] = is_16 ? fg_code : fg_red;
        slot_val[1] = fg_green;
        slot_val[2] = fg_blue;
        slot_val[3] = is_16 ? bg_code_10 : bg_red;
        slot_val[4] = bg_green;
        slot_val[5] = bg_blue;
    end

    genvar g;
    generate
        for (g = 0; g < acfm_pkg::ACFM_SLOTS; g++)
        begin : g_dec
            assign dec_res[g] = dec8(slot_val[g]);
        end
    endgenerate

    // Build the job record
    always_comb
    begin
        job            = '0;
        job.home       = s_tuser & screen_ctrl_reg;
        job.true_color = (color_depth_reg == DEPTH_TRUE);
        job.color_16   = is_16;
        job.with_bg    = ~transp_bg_reg;
        job.row_end    = s_tlast;
        for (int k = 0; k < acfm_pkg::ACFM_SLOTS; k++)
        begin
            job.digits[k] = dec_res[k][11:0];
            job.dlen[k]   = dec_res[k][13:12];
        end
        // UTF-8 by plain length rule
        if (codepoint[20:7] == 14'd0)
        begin
            job.utf[0] = codepoint[7:0];
            job.ulen   = 3'd1;
        end
        else if (codepoint[20:11] == 10'd0)
        begin
            job.utf[0] = {3'b110, codepoint[10:6]};
            job.utf[1] = {2'b10, codepoint[5:0]};
            job.ulen   = 3'd2;
        end
        else if (codepoint[20:16] == 5'd0)
        begin
            job.utf[0] = {4'b1110, codepoint[15:12]};
            job.utf[1] = {2'b10, codepoint[11:6]};
            job.utf[2] = {2'b10, codepoint[5:0]};
            job.ulen   = 3'd3;
        end
        else
        begin
            job.utf[0] = {5'b11110, codepoint[20:18]};
            job.utf[1] = {2'b10, codepoint[17:12]};
            job.utf[2] = {2'b10, codepoint[11:6]};
            job.utf[3] = {2'b10, codepoint[5:0]};
            job.ulen   = 3'd4;
        end
    end

    assign job_valid = s_tvalid;
    assign s_tready  = job_ready;

endmodule

// ===== sv/acfm_queue.sv =====
// Short job queue between front end and back end.
// Register-based FIFO of acfm_job_t records. Depends on acfm_pkg.
module acfm_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  acfm_pkg::acfm_job_t wr_data,
    output logic                rd_valid,
    output acfm_pkg::acfm_job_t rd_data,
    input  logic                rd_pop
);

    localparam int PW = acfm_pkg::ACFM_QPTR_W;
    localparam int CW = acfm_pkg::ACFM_QCNT_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(acfm_pkg::ACFM_QDEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(acfm_pkg::ACFM_QDEPTH);

    acfm_pkg::acfm_job_t mem_reg [acfm_pkg::ACFM_QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_pop & rd_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/acfm_back.sv =====
// Back end: walks one job segment by segment and sends one byte per cycle while the output is not stalled.
// Output register holds each byte until the downstream ready takes it.
// Depends on acfm_pkg.
module acfm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  acfm_pkg::acfm_job_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_HOME  = 10'b00_0000_0010,
        ST_OPEN  = 10'b00_0000_0100,
        ST_FGNUM = 10'b00_0000_1000,
        ST_BGPRE = 10'b00_0001_0000,
        ST_BGNUM = 10'b00_0010_0000,
        ST_M     = 10'b00_0100_0000,
        ST_UTF   = 10'b00_1000_0000,
        ST_RST   = 10'b01_0000_0000,
        ST_NL    = 10'b10_0000_0000
    } acfm_state_t;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B; // [
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_TWO  = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;
    localparam logic [7:0] CH_FOUR = 8'h34;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_NL   = 8'h0A;

    acfm_state_t st_reg, st_next, eff_st;
    logic [2:0]  cnt_reg, cnt_next, eff_cnt;
    logic [2:0]  num_reg, num_next, eff_num;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic [9:0]  seg_en, first_vec, eff_vec, nxt_vec;
    logic        idle, color, emit, seg_last, num_adv, final_byte;
    logic [7:0]  cur_byte;
    logic [2:0]  nlen, grp_end;
    logic [3:0]  digit;

    // Lowest enabled segment strictly after the current one
    function automatic logic [9:0] next_seg(input logic [9:0] en, input logic [9:0] cur);
        logic [9:0] m;
        m = en & ~((cur << 1) - 10'd1);
        return m & (~m + 10'd1);
    endfunction

    function automatic logic [2:0] start_num(input acfm_state_t s);
        return (s == ST_BGNUM) ? 3'd3 : 3'd0;
    endfunction

    // Segment enables for the head job
    always_comb
    begin
        color     = head.true_color | head.color_16;
        seg_en    = '0;
        seg_en[1] = head.home;
        seg_en[2] = color;
        seg_en[3] = color;
        seg_en[4] = color & head.with_bg;
        seg_en[5] = color & head.with_bg;
        seg_en[6] = color;
        seg_en[7] = 1'b1;
        seg_en[8] = color & head.row_end;
        seg_en[9] = head.row_end;
    end

    assign idle      = (st_reg == ST_IDLE);
    assign first_vec = next_seg(seg_en, ST_IDLE);
    assign eff_vec   = idle ? first_vec : st_reg;
    assign eff_st    = acfm_state_t'(eff_vec);
    assign eff_cnt   = idle ? 3'd0 : cnt_reg;
    assign eff_num   = idle ? start_num(eff_st) : num_reg;
    assign nxt_vec   = next_seg(seg_en, eff_vec);

    assign nlen  = {1'b0, head.dlen[eff_num]};
    assign digit = head.digits[eff_num][eff_cnt[1:0]];

    // Select the byte of the current segment
    always_comb
    begin
        cur_byte = 8'h00;
        seg_last = 1'b1;
        num_adv  = 1'b0;
        grp_end  = 3'd0;
        case (eff_st)
            ST_HOME:
            begin
                case (eff_cnt)
                    3'd0:    cur_byte = CH_ESC;
                    3'd1:    cur_byte = CH_LBR;
                    default: cur_byte = CH_H;
                endcase
                seg_last = (eff_cnt == 3'd2);
            end
            ST_OPEN:
            begin
                case (eff_cnt)
                    3'd0:    cur_byte = CH_ESC;
                    3'd1:    cur_byte = CH_LBR;
                    3'd2:    cur_byte = CH_THREE;
                    3'd3:    cur_byte = CH_EIGHT;
                    3'd5:    cur_byte = CH_TWO;
                    default: cur_byte = CH_SEMI;
                endcase
                seg_last = head.true_color ? (eff_cnt == 3'd6) : (eff_cnt == 3'd1);
            end
            ST_FGNUM, ST_BGNUM:
            begin
                if (eff_st == ST_FGNUM)
                    grp_end = head.true_color ? 3'd2 : 3'd0;
                else
                    grp_end = head.true_color ? 3'd5 : 3'd3;
                cur_byte = (eff_cnt < nlen) ? (CH_ZERO | {4'h0, digit}) : CH_SEMI;
                seg_last = (eff_num == grp_end) && (eff_cnt == nlen - 3'd1);
                num_adv  = (eff_cnt == nlen);
            end
            ST_BGPRE:
            begin
                case (eff_cnt)
                    3'd1:    cur_byte = CH_FOUR;
                    3'd2:    cur_byte = CH_EIGHT;
                    3'd4:    cur_byte = CH_TWO;
                    default: cur_byte = CH_SEMI;
                endcase
                seg_last = head.true_color ? (eff_cnt == 3'd5) : (eff_cnt == 3'd0);
            end
            ST_M:
            begin
                cur_byte = CH_M;
            end
            ST_UTF:
            begin
                cur_byte = head.utf[eff_cnt[1:0]];
                seg_last = (eff_cnt == head.ulen - 3'd1);
            end
            ST_RST:
            begin
                case (eff_cnt)
                    3'd0:    cur_byte = CH_ESC;
                    3'd1:    cur_byte = CH_LBR;
                    3'd2:    cur_byte = CH_ZERO;
                    default: cur_byte = CH_M;
                endcase
                seg_last = (eff_cnt == 3'd3);
            end
            ST_NL:
            begin
                cur_byte = CH_NL;
            end
            default:
            begin
                cur_byte = 8'h00;
                seg_last = 1'b1;
            end
        endcase
    end

    assign emit       = head_valid & (~out_valid_reg | m_tready);
    assign final_byte = seg_last & (nxt_vec == 10'd0);
    assign pop        = emit & final_byte;

    // Advance the sequencer
    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        num_next = num_reg;
        if (emit)
        begin
            st_next  = eff_st;
            cnt_next = eff_cnt + 3'd1;
            num_next = eff_num;
            if (seg_last)
            begin
                cnt_next = 3'd0;
                if (nxt_vec == 10'd0)
                begin
                    st_next  = ST_IDLE;
                    num_next = 3'd0;
                end
                else
                begin
                    st_next  = acfm_state_t'(nxt_vec);
                    num_next = start_num(acfm_state_t'(nxt_vec));
                end
            end
            else if (num_adv)
            begin
                cnt_next = 3'd0;
                num_next = eff_num + 3'd1;
            end
        end
        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cnt_reg       <= 3'd0;
            num_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            num_reg       <= num_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= final_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sv/ansi_cell_stream_formatter_unit.sv =====
// Top level of the ANSI cell stream formatter: front end, job queue, back end.
// Depends on acfm_pkg, acfm_front, acfm_queue and acfm_back.
//
//   channel   direction  beat
//   s_*       in         one text cell (colours, codes, codepoint, frame/row marks)
//   m_*       out        one terminal byte, tlast on the cell's final byte
//   cfg_*     in         register write: 0 color_depth, 1 transparent_bg, 2 screen_ctrl
//
// A cell has 1 to 48 output bytes; the back end's byte sequencer sends one byte
// per cycle while m_tready does not stall it, and sets the rate.
// The front end classifies a cell in the cycle it is accepted and queues it
// (two entries), so cells are taken while the back end still works.
// Reset clears the queue and sequencer and loads the configuration defaults.
// A stalled m_tready holds the output beat; the queue absorbs input meanwhile.
module ansi_cell_stream_formatter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_wdata,
    // cell input
    input  logic        s_tvalid,
    output logic        s_tready,
    // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue, fg_code, bg_code,
    // codepoint[84:64], zero fill [87:85]
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,   // frame_start
    input  logic        s_tlast,   // row_end
    // byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast    // last_byte
);

    acfm_pkg::acfm_job_t wr_job, head_job;
    logic wr_valid, wr_ready, head_valid, head_pop;

    acfm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .job_valid (wr_valid),
        .job_ready (wr_ready),
        .job       (wr_job)
    );

    acfm_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_job),
        .rd_valid (head_valid),
        .rd_data  (head_job),
        .rd_pop   (head_pop)
    );

    acfm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_job),
        .pop        (head_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
